/* src/fqkr_pkg.sv */
// ----------------------------------------------------------------------------
// FIFO queue with key removal: shared definitions
// Field widths, operation codes, default sizes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fqkr_pkg;

   // Default sizes for the top-level parameters
   localparam int DEPTH_DEFAULT     = 16;
   localparam int CODE_BITS_DEFAULT = 16;

   // Fixed port field widths
   localparam int FUNC_W      = 3;
   localparam int KEY_W       = 16;
   localparam int CODE_OUT_W  = 16;
   localparam int COUNT_OUT_W = 5;

   // Width used to zero-extend codes before trimming to the stored width
   localparam int WIDE_W = 32;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_PUSH     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP      = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_CONTAINS = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd4;

   // Controller to datapath
   typedef struct packed {
      logic accept;     // latch the incoming request
      logic start;      // first execution cycle of the request
      logic pop_take;   // head read data is valid, retire the head entry
      logic scan_step;  // one entry of the walk is valid in the read register
      logic load_rsp;   // move the finished result into the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              empty;
      logic              last;   // current walk entry is the final stored entry
      logic              match;  // current walk entry equals the request key
   } status_type;

endpackage

/* src/fqkr_req_if.sv */
// ----------------------------------------------------------------------------
// FIFO queue request channel
// Valid/ready channel carrying the operation and the key code.
// ----------------------------------------------------------------------------
interface fqkr_req_if;
   logic                           valid;
   logic                           ready;
   logic [fqkr_pkg::FUNC_W-1:0]    func;
   logic [fqkr_pkg::KEY_W-1:0]     key_code;

   modport source (output valid, output func, output key_code, input ready);
   modport sink   (input valid, input func, input key_code, output ready);
endinterface

/* src/fqkr_rsp_if.sv */
// ----------------------------------------------------------------------------
// FIFO queue response channel
// Valid/ready channel carrying status flags, the popped code and the count.
// ----------------------------------------------------------------------------
interface fqkr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              ok;
   logic                              found;
   logic [fqkr_pkg::CODE_OUT_W-1:0]   code_out;
   logic [fqkr_pkg::COUNT_OUT_W-1:0]  count;

   modport source (output valid, output ok, output found, output code_out,
                   output count, input ready);
   modport sink   (input valid, input ok, input found, input code_out,
                   input count, output ready);
endinterface

/* src/fqkr_dpath.sv */
// ----------------------------------------------------------------------------
// FIFO queue datapath
// Circular entry memory with a registered read port, head and count
// registers, the walk counters for contains and remove, and the result
// output register.
// ----------------------------------------------------------------------------
module fqkr_dpath #(
   parameter int DEPTH     = fqkr_pkg::DEPTH_DEFAULT,
   parameter int CODE_BITS = fqkr_pkg::CODE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  fqkr_pkg::cmd_type                  cmd,
   output fqkr_pkg::status_type               status,
   input  logic [fqkr_pkg::FUNC_W-1:0]        req_func,
   input  logic [fqkr_pkg::KEY_W-1:0]         req_key_code,
   output logic                               rsp_ok,
   output logic                               rsp_found,
   output logic [fqkr_pkg::CODE_OUT_W-1:0]    rsp_code_out,
   output logic [fqkr_pkg::COUNT_OUT_W-1:0]   rsp_count
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW:0]   DEPTH_SUM = (CW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_CNT   = CW'(1);

   // Wrap head plus offset into the circular store
   function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                             input logic [CW-1:0] offs);
      logic [CW:0] sum;
      sum = (CW + 1)'(head) + (CW + 1)'(offs);
      if (sum >= DEPTH_SUM) begin
         sum = sum - DEPTH_SUM;
      end
      return sum[IW-1:0];
   endfunction

   logic [CODE_BITS-1:0] entry_mem [DEPTH];
   logic [CODE_BITS-1:0] rdata_ff;
   logic [IW-1:0]        rd_addr;

   logic [fqkr_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [CODE_BITS-1:0]        key_ff, key_in;
   logic [IW-1:0]               head_ff, head_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               scan_ff, scan_in;
   logic [CW-1:0]               kept_ff, kept_in;
   logic                        ok_ff, ok_in;
   logic                        found_ff, found_in;
   logic [CODE_BITS-1:0]        code_ff, code_in;

   logic                        out_ok_ff, out_ok_in;
   logic                        out_found_ff, out_found_in;
   logic [CODE_BITS-1:0]        out_code_ff, out_code_in;
   logic [CW-1:0]               out_count_ff, out_count_in;

   logic                        wr_en;
   logic [IW-1:0]               wr_addr;
   logic [CODE_BITS-1:0]        wr_data;

   logic [fqkr_pkg::WIDE_W-1:0] key_wide;
   logic [fqkr_pkg::WIDE_W-1:0] code_wide;
   logic [fqkr_pkg::WIDE_W-1:0] count_wide;
   logic [CW-1:0]               scan_next;
   logic                        match;
   logic                        empty;
   logic                        full;

   // Trim the incoming key to the stored code width
   assign key_wide  = fqkr_pkg::WIDE_W'(req_key_code);
   assign scan_next = scan_ff + ONE_CNT;
   assign match     = (rdata_ff == key_ff);
   assign empty     = (count_ff == '0);
   assign full      = (count_ff >= DEPTH_CNT);

   // Report to the controller
   assign status.func  = func_ff;
   assign status.empty = empty;
   assign status.last  = (scan_next == count_ff);
   assign status.match = match;

   // Read the head on the first cycle, then the next walk entry each cycle
   assign rd_addr = cmd.start ? head_ff : slot_of(head_ff, scan_next);

   // Next-state logic for the working registers
   always_comb begin
      func_in      = func_ff;
      key_in       = key_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      kept_in      = kept_ff;
      ok_in        = ok_ff;
      found_in     = found_ff;
      code_in      = code_ff;
      out_ok_in    = out_ok_ff;
      out_found_in = out_found_ff;
      out_code_in  = out_code_ff;
      out_count_in = out_count_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_of(head_ff, count_ff);
      wr_data      = key_ff;

      if (cmd.accept) begin
         func_in = req_func;
         key_in  = key_wide[CODE_BITS-1:0];
      end

      if (cmd.start) begin
         ok_in    = 1'b1;
         found_in = 1'b0;
         code_in  = '0;
         scan_in  = '0;
         kept_in  = '0;
         case (func_ff)
            fqkr_pkg::FUNC_PUSH: begin
               if (full) begin
                  ok_in = 1'b0;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + ONE_CNT;
               end
            end
            fqkr_pkg::FUNC_POP: begin
               ok_in = !empty;
            end
            fqkr_pkg::FUNC_CLEAR: begin
               head_in  = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end

      // Retire the head entry
      if (cmd.pop_take) begin
         code_in  = rdata_ff;
         head_in  = slot_of(head_ff, ONE_CNT);
         count_in = count_ff - ONE_CNT;
      end

      // Walk one entry: flag a hit, or compact the survivors toward the head
      if (cmd.scan_step) begin
         scan_in = scan_next;
         if (func_ff == fqkr_pkg::FUNC_CONTAINS && match) begin
            found_in = 1'b1;
         end
         if (func_ff == fqkr_pkg::FUNC_REMOVE) begin
            if (!match) begin
               wr_en   = 1'b1;
               wr_addr = slot_of(head_ff, kept_ff);
               wr_data = rdata_ff;
               kept_in = kept_ff + ONE_CNT;
            end
            if (status.last) begin
               count_in = match ? kept_ff : kept_ff + ONE_CNT;
            end
         end
      end

      // Hand the finished result to the output register
      if (cmd.load_rsp) begin
         out_ok_in    = ok_ff;
         out_found_in = found_ff;
         out_code_in  = code_ff;
         out_count_in = count_ff;
      end
   end

   // Entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= entry_mem[rd_addr];
   end

   // Queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Request, walk and result payload
   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      key_ff       <= key_in;
      scan_ff      <= scan_in;
      kept_ff      <= kept_in;
      ok_ff        <= ok_in;
      found_ff     <= found_in;
      code_ff      <= code_in;
      out_ok_ff    <= out_ok_in;
      out_found_ff <= out_found_in;
      out_code_ff  <= out_code_in;
      out_count_ff <= out_count_in;
   end

   // Widen to the port widths
   assign code_wide    = fqkr_pkg::WIDE_W'(out_code_ff);
   assign count_wide   = fqkr_pkg::WIDE_W'(out_count_ff);
   assign rsp_ok       = out_ok_ff;
   assign rsp_found    = out_found_ff;
   assign rsp_code_out = code_wide[fqkr_pkg::CODE_OUT_W-1:0];
   assign rsp_count    = count_wide[fqkr_pkg::COUNT_OUT_W-1:0];

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count exceeds depth");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> scan_ff < count_ff)
      else $error("walk index past stored entries");

   a_kept_behind: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> kept_ff <= scan_ff)
      else $error("compaction write overtook the read index");
`endif

endmodule

/* src/fqkr_ctrl.sv */
// ----------------------------------------------------------------------------
// FIFO queue controller
// Sequences each request through start, pop or walk cycles and a finish
// cycle, and owns the handshake flags of both channels.
// ----------------------------------------------------------------------------
module fqkr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fqkr_pkg::cmd_type     cmd,
   input  fqkr_pkg::status_type  status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_POP,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Decode commands from the current state
   assign cmd.accept    = (state_ff == ST_IDLE) && req_valid;
   assign cmd.start     = (state_ff == ST_START);
   assign cmd.pop_take  = (state_ff == ST_POP);
   assign cmd.scan_step = (state_ff == ST_SCAN);
   assign cmd.load_rsp  = (state_ff == ST_FINISH) && out_free;

   // Advance the sequence
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (status.func == fqkr_pkg::FUNC_POP && !status.empty) begin
               state_in = ST_POP;
            end else if (status.func inside {fqkr_pkg::FUNC_CONTAINS,
                                             fqkr_pkg::FUNC_REMOVE}
                         && !status.empty) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_POP: begin
            state_in = ST_FINISH;
         end
         ST_SCAN: begin
            if (status.last ||
                (status.func == fqkr_pkg::FUNC_CONTAINS && status.match)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the response valid until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> state_ff == ST_START)
      else $error("accepted request did not start");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("loaded response not presented");

   a_last_finishes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && status.last) |=> state_ff == ST_FINISH)
      else $error("walk ran past the last entry");
`endif

endmodule

/* src/fifo_queue_with_key_removal_unit.sv */
// ----------------------------------------------------------------------------
// FIFO queue with key removal
// Fixed-depth queue of task codes supporting push, pop, contains, remove of
// every matching entry (order of the rest kept) and clear.
//
//   channel  | dir | payload                         | handshake
//   ---------+-----+---------------------------------+-------------
//   req_ch   | in  | func, key_code                  | valid/ready
//   rsp_ch   | out | ok, found, code_out, count      | valid/ready
//
// One request at a time: accept, the start state, then the pop state for pop
// or a walk of the stored entries for contains and remove (contains stops at
// the first hit) through the single read port of the entry memory, then the
// finish state. The result sits in an output register, so a stalled response
// only holds the finish cycle. Reset clears head, count and control; the
// entry memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module fifo_queue_with_key_removal_unit #(
   parameter int DEPTH     = fqkr_pkg::DEPTH_DEFAULT,
   parameter int CODE_BITS = fqkr_pkg::CODE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   fqkr_req_if.sink    req_ch,
   fqkr_rsp_if.source  rsp_ch
);

   fqkr_pkg::cmd_type    cmd;
   fqkr_pkg::status_type status;

   // Sequence control
   fqkr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Storage and result path
   fqkr_dpath #(
      .DEPTH     (DEPTH),
      .CODE_BITS (CODE_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_func     (req_ch.func),
      .req_key_code (req_ch.key_code),
      .rsp_ok       (rsp_ch.ok),
      .rsp_found    (rsp_ch.found),
      .rsp_code_out (rsp_ch.code_out),
      .rsp_count    (rsp_ch.count)
   );

endmodule

/* tb/tb_fifo_queue_with_key_removal_unit.sv */
// ----------------------------------------------------------------------------
// FIFO queue with key removal: self-checking testbench
// Runs a short directed list of requests (empty and full queue, duplicate
// codes, extreme codes, unused operations), then random fill and drain
// streams over a small pool of codes, so lookups and removals hit often.
// A shadow queue in the testbench computes every status, and each response
// is checked against it. Both channels idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module tb_fifo_queue_with_key_removal_unit;

   localparam int FUNC_W         = fqkr_pkg::FUNC_W;
   localparam int KEY_W          = fqkr_pkg::KEY_W;
   localparam int CODE_OUT_W     = fqkr_pkg::CODE_OUT_W;
   localparam int COUNT_OUT_W    = fqkr_pkg::COUNT_OUT_W;
   localparam int QUEUE_DEPTH    = fqkr_pkg::DEPTH_DEFAULT;
   localparam int HEAD_W         = $clog2(QUEUE_DEPTH);
   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 1225;
   localparam int POOL_SIZE      = 6;
   localparam int DRAIN_CYCLES   = QUEUE_DEPTH + 8;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [FUNC_W-1:0] FUNC_LAST = '1;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [KEY_W-1:0]  key_code;
   } queue_cmd_type;

   typedef struct packed {
      logic                   ok;
      logic                   found;
      logic [CODE_OUT_W-1:0]  code_out;
      logic [COUNT_OUT_W-1:0] count;
   } queue_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fqkr_req_if req_ch ();
   fqkr_rsp_if rsp_ch ();

   fifo_queue_with_key_removal_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the queue
   logic [KEY_W-1:0]       shadow_mem [QUEUE_DEPTH];
   logic [HEAD_W-1:0]      shadow_head = '0;
   logic [COUNT_OUT_W-1:0] shadow_fill = '0;

   queue_cmd_type    cmd_backlog [$];
   queue_status_type status_due_q [$];

   int total_cmds     = 0;
   int cmds_taken     = 0;
   int mismatch_cnt   = 0;
   int op_tally [8];
   int push_refused   = 0;
   int pop_on_empty   = 0;
   int lookup_hits    = 0;
   int entries_purged = 0;
   int peak_fill      = 0;

   // Clock
   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   function automatic int slot_at(int offset);
      return (int'(shadow_head) + offset) % QUEUE_DEPTH;
   endfunction

   // Apply one request to the shadow queue and queue up the status it yields
   task automatic apply_queue_op(input logic [FUNC_W-1:0] op,
                                 input logic [KEY_W-1:0] key);
      queue_status_type st;
      int               kept;
      logic [KEY_W-1:0] v;
      st = '{ok: 1'b1, found: 1'b0, code_out: '0, count: '0};
      case (op)
         fqkr_pkg::FUNC_PUSH: begin
            if (shadow_fill == QUEUE_DEPTH) begin
               st.ok = 1'b0;
               push_refused++;
            end else begin
               shadow_mem[slot_at(shadow_fill)] = key;
               shadow_fill++;
            end
         end
         fqkr_pkg::FUNC_POP: begin
            if (shadow_fill == 0) begin
               st.ok = 1'b0;
               pop_on_empty++;
            end else begin
               st.code_out = shadow_mem[shadow_head];
               shadow_head = HEAD_W'(slot_at(1));
               shadow_fill--;
            end
         end
         fqkr_pkg::FUNC_CONTAINS: begin
            for (int i = 0; i < shadow_fill; i++) begin
               if (shadow_mem[slot_at(i)] == key) begin
                  st.found = 1'b1;
                  lookup_hits++;
                  break;
               end
            end
         end
         fqkr_pkg::FUNC_REMOVE: begin
            // compact survivors toward the head, order kept
            kept = 0;
            for (int i = 0; i < shadow_fill; i++) begin
               v = shadow_mem[slot_at(i)];
               if (v != key) begin
                  shadow_mem[slot_at(kept)] = v;
                  kept++;
               end
            end
            entries_purged += shadow_fill - kept;
            shadow_fill = COUNT_OUT_W'(kept);
         end
         fqkr_pkg::FUNC_CLEAR: begin
            shadow_fill = '0;
            shadow_head = '0;
         end
         default: ;
      endcase
      st.count = shadow_fill;
      if (shadow_fill > peak_fill) peak_fill = shadow_fill;
      op_tally[op]++;
      status_due_q.push_back(st);
   endtask

   task automatic note_mismatch(input string what, input queue_status_type want,
                                input queue_status_type got);
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_LIMIT)
         $display({"mismatch (%s) at %0t: expected ok=%0b found=%0b code=%h count=%0d,",
                   " got ok=%0b found=%0b code=%h count=%0d"},
                  what, $realtime, want.ok, want.found, want.code_out, want.count,
                  got.ok, got.found, got.code_out, got.count);
   endtask

   // Idle rates per phase: sender light / receiver heavy, then swapped, then none
   function automatic int sender_idle_pct();
      if (cmds_taken < total_cmds / 3) return 20;
      if (cmds_taken < 2 * total_cmds / 3) return 81;
      return 0;
   endfunction

   function automatic int receiver_stall_pct();
      if (cmds_taken < total_cmds / 3) return 81;
      if (cmds_taken < 2 * total_cmds / 3) return 20;
      return 0;
   endfunction

   task automatic add_cmd(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] key);
      cmd_backlog.push_back('{func: op, key_code: key});
   endtask

   // Request driver: predict on acceptance, then present the next request
   always @(posedge clock) begin
      queue_cmd_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_queue_op(req_ch.func, req_ch.key_code);
            cmds_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (cmd_backlog.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct()) begin
               nxt = cmd_backlog.pop_front();
               req_ch.valid    <= 1'b1;
               req_ch.func     <= nxt.func;
               req_ch.key_code <= nxt.key_code;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check against the oldest due status, then pick ready
   always @(posedge clock) begin
      queue_status_type got;
      queue_status_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{ok: rsp_ch.ok, found: rsp_ch.found, code_out: rsp_ch.code_out,
                    count: rsp_ch.count};
            if (status_due_q.size() == 0) begin
               note_mismatch("unexpected response", '0, got);
            end else begin
               want = status_due_q.pop_front();
               if (got.ok !== want.ok || got.found !== want.found ||
                   got.code_out !== want.code_out || got.count !== want.count)
                  note_mismatch("field", want, got);
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct());
      end
   end

   // Stimulus and end of run
   initial begin
      logic [KEY_W-1:0] fill_keys [QUEUE_DEPTH];
      logic [KEY_W-1:0] key_pool [POOL_SIZE];
      logic [FUNC_W-1:0] op;
      logic [KEY_W-1:0] key;
      int roll;
      bit fill_bias;

      req_ch.valid    = 1'b0;
      req_ch.func     = fqkr_pkg::FUNC_PUSH;
      req_ch.key_code = '0;
      rsp_ch.ready    = 1'b0;

      // Directed: empty queue, unused codes, fill with duplicates, overflow
      add_cmd(fqkr_pkg::FUNC_POP, 16'h0000);
      add_cmd(fqkr_pkg::FUNC_CLEAR, 16'hFFFF);
      add_cmd(FUNC_LAST, 16'hFFFF);
      fill_keys = '{16'hFFFF, 16'h0000, 16'hA5A5, 16'hFFFF, 16'h5A5A, 16'h0001,
                    16'h8000, 16'hFFFF, 16'h7FFF, 16'hFFFE, 16'h0000, 16'h1234,
                    16'hFFFF, 16'h00FF, 16'hFF00, 16'h0000};
      foreach (fill_keys[i]) add_cmd(fqkr_pkg::FUNC_PUSH, fill_keys[i]);
      add_cmd(fqkr_pkg::FUNC_PUSH, 16'hBEEF);
      add_cmd(fqkr_pkg::FUNC_CONTAINS, 16'hFFFF);
      add_cmd(fqkr_pkg::FUNC_REMOVE, 16'hFFFF);
      add_cmd(fqkr_pkg::FUNC_POP, 16'h0000);
      add_cmd(fqkr_pkg::FUNC_CLEAR + 3'd1, 16'h5555);
      add_cmd(fqkr_pkg::FUNC_CLEAR, 16'h0000);

      // Random: alternate fill-heavy and drain-heavy stretches over a small pool
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) begin
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int p = 2; p < POOL_SIZE; p++) key_pool[p] = KEY_W'($urandom);
         end
         fill_bias = ((n / 48) % 2) == 0;
         roll = $urandom_range(99);
         if (fill_bias)
            op = roll < 62 ? fqkr_pkg::FUNC_PUSH : roll < 76 ? fqkr_pkg::FUNC_POP :
                 roll < 87 ? fqkr_pkg::FUNC_CONTAINS :
                 roll < 95 ? fqkr_pkg::FUNC_REMOVE :
                 roll < 97 ? fqkr_pkg::FUNC_CLEAR :
                 FUNC_W'($urandom_range(fqkr_pkg::FUNC_CLEAR + 1, FUNC_LAST));
         else
            op = roll < 22 ? fqkr_pkg::FUNC_PUSH : roll < 60 ? fqkr_pkg::FUNC_POP :
                 roll < 78 ? fqkr_pkg::FUNC_CONTAINS :
                 roll < 94 ? fqkr_pkg::FUNC_REMOVE :
                 roll < 97 ? fqkr_pkg::FUNC_CLEAR :
                 FUNC_W'($urandom_range(fqkr_pkg::FUNC_CLEAR + 1, FUNC_LAST));
         key = ($urandom_range(3) != 0) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                        : KEY_W'($urandom_range(16'hFFFF));
         add_cmd(op, key);
      end
      total_cmds = cmd_backlog.size();

      // Release reset after the reset window
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      wait (cmds_taken == total_cmds);
      wait (status_due_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display({"Covered %0d requests: %0d push (%0d refused when full),",
                " %0d pop (%0d on empty), %0d contains (%0d hits)"},
               total_cmds, op_tally[fqkr_pkg::FUNC_PUSH], push_refused,
               op_tally[fqkr_pkg::FUNC_POP], pop_on_empty,
               op_tally[fqkr_pkg::FUNC_CONTAINS], lookup_hits);
      $display("%0d remove (%0d entries dropped), %0d clear, peak count %0d, %0d mismatches",
               op_tally[fqkr_pkg::FUNC_REMOVE], entries_purged,
               op_tally[fqkr_pkg::FUNC_CLEAR], peak_fill, mismatch_cnt);
      if (mismatch_cnt == 0) begin
         $display("[fifo_queue_with_key_removal_unit] OK");
      end else begin
         $display("[fifo_queue_with_key_removal_unit] ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
      $display("timeout: %0d of %0d requests taken, %0d responses outstanding",
               cmds_taken, total_cmds, status_due_q.size());
      $display("[fifo_queue_with_key_removal_unit] ERROR");
      $finish;
   end

endmodule
